[rtl/afb_pkg.sv]
`default_nettype none

package afb_pkg;

  localparam int SampleW   = 16;
  localparam int OutW      = 24;
  localparam int CoefW     = 15;
  localparam int HistDepth = 6;
  localparam int AvgLen    = 5;
  localparam int FirTaps   = 6;

  localparam logic [CoefW-1:0] IirFeedbackReset = CoefW'(26214);
  localparam logic [CoefW-1:0] IirInputReset    = CoefW'(6554);

  // Q15 taps, sum 32768
  localparam int FirTap [FirTaps] = '{646, 4338, 11400, 11400, 4338, 646};

  // b * sample product
  localparam int BsW = CoefW + SampleW;

  typedef enum logic [0:0] {
    RegIirFeedback = 1'b0,
    RegIirInput    = 1'b1
  } cfg_reg_t;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef sample_t [HistDepth-1:0] hist_t;
  typedef logic signed [OutW-1:0] out_t;

  typedef struct packed {
    hist_t                 hist;
    logic signed [BsW-1:0] bs;
  } s1_data_t;

  function automatic out_t sat24(input logic signed [47:0] v);
    out_t r;
    if (v > 48'sd8388607) begin
      r = out_t'(24'sh7fffff);
    end else if (v < -48'sd8388608) begin
      r = out_t'(24'sh800000);
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/afb_input_stage.sv]
`default_nettype none

module afb_input_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire afb_pkg::sample_t               sample,
  input  wire logic [afb_pkg::CoefW-1:0]      iir_input_coef,
  output afb_pkg::s1_data_t                   s1
);

  afb_pkg::hist_t                   hist;
  logic signed [afb_pkg::BsW-1:0]   bs;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (load) begin
      hist <= {hist[afb_pkg::HistDepth-2:0], sample};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bs <= afb_pkg::BsW'($signed({1'b0, iir_input_coef})) * afb_pkg::BsW'(sample);
    end
  end

  assign s1.hist = hist;
  assign s1.bs   = bs;

endmodule

`default_nettype wire

[rtl/afb_fir_avg.sv]
`default_nettype none

module afb_fir_avg (
  input  wire afb_pkg::hist_t  hist,
  output afb_pkg::out_t        average_out,
  output afb_pkg::out_t        fir_out
);

  localparam int AvgSumW = afb_pkg::SampleW + 3;
  localparam int AvgMagW = AvgSumW + 8;
  localparam int AvgShift = AvgMagW + $clog2(afb_pkg::AvgLen);
  localparam longint unsigned AvgRecipL =
    ((64'd1 << AvgShift) + afb_pkg::AvgLen - 1) / afb_pkg::AvgLen;
  localparam logic [AvgShift:0] AvgRecip = AvgRecipL[AvgShift:0];
  localparam int FirW = 34;

  logic signed [AvgSumW-1:0]        sum;
  logic                             neg;
  logic [AvgSumW-1:0]               mag;
  logic [AvgMagW-1:0]               mag_q8;
  logic [AvgMagW+AvgShift:0]        prod;
  logic [AvgMagW-1:0]               quot;
  logic signed [47:0]               avg_s;
  logic signed [FirW-1:0]           fir_acc;

  always_comb begin
    sum = '0;
    for (int k = 0; k < afb_pkg::AvgLen; k++) begin
      sum = sum + AvgSumW'(hist[k]);
    end
    neg    = sum[AvgSumW-1];
    mag    = neg ? AvgSumW'(-sum) : AvgSumW'(sum);
    // round half away from zero on the magnitude
    mag_q8 = {mag, 8'b0} + AvgMagW'(afb_pkg::AvgLen / 2);
    // exact floor divide by the average length via reciprocal
    prod   = (AvgMagW+AvgShift+1)'(mag_q8) * (AvgMagW+AvgShift+1)'(AvgRecip);
    quot   = prod[AvgShift +: AvgMagW];
    avg_s  = neg ? -$signed(48'(quot)) : $signed(48'(quot));
  end

  assign average_out = afb_pkg::sat24(avg_s);

  always_comb begin
    fir_acc = FirW'(64);
    for (int k = 0; k < afb_pkg::FirTaps; k++) begin
      fir_acc = fir_acc + FirW'(hist[k]) * FirW'(afb_pkg::FirTap[k]);
    end
  end

  assign fir_out = afb_pkg::sat24(48'(fir_acc >>> 7));

endmodule

`default_nettype wire

[rtl/afb_iir.sv]
`default_nettype none

module afb_iir (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire logic [afb_pkg::CoefW-1:0]       iir_feedback_coef,
  input  wire logic signed [afb_pkg::BsW-1:0]  bs,
  output afb_pkg::out_t                        acc_next,
  output afb_pkg::out_t                        acc
);

  logic signed [39:0] fb_prod;
  logic signed [41:0] total;

  assign fb_prod  = 40'($signed({1'b0, iir_feedback_coef})) * 40'(acc);
  assign total    = 42'(fb_prod) + (42'(bs) <<< 8) + 42'sd16384;
  assign acc_next = afb_pkg::sat24(48'(total >>> 15));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

[rtl/accel_filter_bank.sv]
// accel_filter_bank: moving average, six-tap FIR and first-order IIR over a
// stream of signed 16-bit accelerometer samples.
// Input stream s_*: one sample per transfer in s_tdata[15:0].
// Output stream m_*: one result per sample, m_tdata = {iir_out, fir_out,
// average_out}, each 24-bit signed Q8 and saturated.
// Config port: cfg_wen/cfg_index/cfg_data writes iir_feedback_coef (index 0)
// or iir_input_coef (index 1); write only while no sample is in flight.
// A sample is registered in the input/history stage, then in the result stage.
// Throughput: one sample per cycle while m_tready is high; the IIR feedback
// multiply-add is combinational from the accumulator register back to itself.
// Two register stages (input/history stage and result stage) hold items, so
// one new sample is still taken while a finished result waits on m_tready.
// When the receiver stalls with both stages full, s_tready drops.
// Reset (rst, synchronous): history and IIR accumulator clear to zero,
// coefficients return to 0.8 and 0.2 (Q15), both stages empty.
`default_nettype none

module accel_filter_bank (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [23:0] average_out, [47:24] fir_out, [71:48] iir_out
  input  wire logic        cfg_wen,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  logic [afb_pkg::CoefW-1:0] iir_feedback_coef;
  logic [afb_pkg::CoefW-1:0] iir_input_coef;

  logic              s1_valid;
  logic              s1_advance;
  logic              s_accept;
  afb_pkg::s1_data_t s1;

  afb_pkg::out_t average_c, fir_c, iir_c, iir_acc;
  afb_pkg::out_t average_out, fir_out, iir_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      iir_feedback_coef <= afb_pkg::IirFeedbackReset;
      iir_input_coef    <= afb_pkg::IirInputReset;
    end else if (cfg_wen) begin
      case (afb_pkg::cfg_reg_t'(cfg_index))
        afb_pkg::RegIirFeedback: iir_feedback_coef <= cfg_data;
        afb_pkg::RegIirInput:    iir_input_coef    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign s_accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  afb_input_stage u_input_stage (
    .clk            (clk),
    .rst            (rst),
    .load           (s_accept),
    .sample         (afb_pkg::sample_t'(s_tdata)),
    .iir_input_coef (iir_input_coef),
    .s1             (s1)
  );

  afb_fir_avg u_fir_avg (
    .hist        (s1.hist),
    .average_out (average_c),
    .fir_out     (fir_c)
  );

  afb_iir u_iir (
    .clk               (clk),
    .rst               (rst),
    .advance           (s1_advance),
    .iir_feedback_coef (iir_feedback_coef),
    .bs                (s1.bs),
    .acc_next          (iir_c),
    .acc               (iir_acc)
  );

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      average_out <= average_c;
      fir_out     <= fir_c;
      iir_out     <= iir_c;
    end
  end

  assign m_tdata = {iir_out, fir_out, average_out};

`ifndef NO_ASSERTIONS
  a_acc_reset: assert property (@(posedge clk) rst |=> iir_acc == '0)
    else $error("IIR accumulator not cleared by reset");

  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(iir_acc))
    else $error("IIR accumulator changed without a result");

  a_out_matches_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> iir_out == iir_acc)
    else $error("iir_out differs from accumulator");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken with both stages full");
`endif

endmodule

`default_nettype wire
